/* rtl/core/base64_stream_decoder_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the decoder RTL
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/b64sd_pkg.sv */
// ---------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and the alphabet lookup for the base64 stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CHAR_BITS  = 8;
    localparam int BYTE_BITS  = 8;
    localparam int SEXT_BITS  = 6;
    localparam int OUT_COUNT_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CHAR_BITS-1:0] CHAR_PAD      = 8'h3D; // '='
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB      = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS     = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_SLASH    = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_HI = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_HI = 8'h7A;

    localparam logic [SEXT_BITS-1:0] SEXT_PLUS  = 6'd62;
    localparam logic [SEXT_BITS-1:0] SEXT_SLASH = 6'd63;

    localparam logic [SEXT_BITS-1:0] LOW4_MASK = 6'h0F;
    localparam logic [SEXT_BITS-1:0] LOW2_MASK = 6'h03;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_DATA    = 2'd0,
        MODE_ONE_PAD = 2'd1,
        MODE_PADDED  = 2'd2
    } mode_t;

    typedef struct packed {
        logic                 ok;
        logic [SEXT_BITS-1:0] value;
    } sextet_t;

    function automatic logic is_white(input logic [CHAR_BITS-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Map one alphabet character to its six-bit value
    function automatic sextet_t sextet_of(input logic [CHAR_BITS-1:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = '0;
        if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI)
        begin
            s.value = SEXT_BITS'(c - CHAR_UPPER_LO);
        end
        else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI)
        begin
            s.value = SEXT_BITS'(c - CHAR_LOWER_LO + 8'd26);
        end
        else if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI)
        begin
            s.value = SEXT_BITS'(c - CHAR_DIGIT_LO + 8'd52);
        end
        else if (c == CHAR_PLUS)
        begin
            s.value = SEXT_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            s.value = SEXT_SLASH;
        end
        else
        begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/base64_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: one text character per beat in, decoded bytes
// and an end-of-text verdict with byte count out.
// ---------------------------------------------------------------------------
// Takes one character per clock and keeps that rate indefinitely as long as
// the output side takes its beats. A beat goes through the input register,
// combinational decode logic and the result register, which drives the
// decoded byte onto the output once the output side is free. White
// space, '=' and characters after an error produce no output beat. An
// end-of-text beat (tlast) yields one result beat with ok or error and the
// saturating byte count, and clears the decoder for the next string. Bytes
// are streamed before the verdict, so drop them when the verdict is error.
`default_nettype none

`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [b64sd_pkg::CHAR_BITS-1:0] s_axis_tdata,  // [7:0] text_char
    input  wire logic                            s_axis_tlast,  // end_of_text
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [39:0]                          m_axis_tdata,  // [7:0] data_byte,
                                                                // [39:8] decoded_count
    output logic [1:0]                           m_axis_tuser   // [1:0] result_kind
);
    import b64sd_pkg::*;

    // input register
    logic                  in_valid_reg, in_valid_next;
    logic [CHAR_BITS-1:0]  in_char_reg;
    logic                  in_end_reg;

    // decoder state
    logic [1:0]            phase_reg, phase_next;
    logic [BYTE_BITS-1:0]  partial_reg, partial_next;
    mode_t                 mode_reg, mode_next;
    logic                  error_reg, error_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    kind_t                     out_kind_reg;
    logic [BYTE_BITS-1:0]      out_byte_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg;

    logic                      out_free;
    logic                      advance;
    logic                      res_valid;
    kind_t                     res_kind;
    logic [BYTE_BITS-1:0]      res_byte;
    logic [OUT_COUNT_BITS-1:0] res_count;
    logic                      bad_end;
    sextet_t                   sext;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;

    assign sext = sextet_of(in_char_reg);

    always_comb
    begin
        bad_end = error_reg
                  || (mode_reg == MODE_DATA && phase_reg != 2'd0)
                  || (mode_reg == MODE_ONE_PAD)
                  || (mode_reg == MODE_PADDED && partial_reg != '0);
    end

    // decode step
    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        mode_next    = mode_reg;
        error_next   = error_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_DATA;
        res_byte     = '0;
        res_count    = '0;

        if (advance)
        begin
            if (in_end_reg)
            begin
                res_valid    = 1'b1;
                res_kind     = bad_end ? KIND_ERR : KIND_OK;
                res_count    = OUT_COUNT_BITS'(count_reg);
                phase_next   = 2'd0;
                partial_next = '0;
                mode_next    = MODE_DATA;
                error_next   = 1'b0;
                count_next   = '0;
            end
            else if (!error_reg && !is_white(in_char_reg))
            begin
                case (mode_reg)
                    MODE_PADDED:
                    begin
                        error_next = 1'b1;
                    end
                    MODE_ONE_PAD:
                    begin
                        if (in_char_reg == CHAR_PAD)
                        begin
                            mode_next = MODE_PADDED;
                        end
                        else
                        begin
                            error_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (in_char_reg == CHAR_PAD)
                        begin
                            if (phase_reg == 2'd2)
                            begin
                                mode_next = MODE_ONE_PAD;
                            end
                            else if (phase_reg == 2'd3)
                            begin
                                mode_next = MODE_PADDED;
                            end
                            else
                            begin
                                error_next = 1'b1;
                            end
                        end
                        else if (!sext.ok)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            case (phase_reg)
                                2'd0:
                                begin
                                    partial_next = {sext.value, 2'b00};
                                end
                                2'd1:
                                begin
                                    res_valid    = 1'b1;
                                    res_byte     = partial_reg | BYTE_BITS'(sext.value >> 4);
                                    partial_next = {4'(sext.value & LOW4_MASK), 4'b0000};
                                end
                                2'd2:
                                begin
                                    res_valid    = 1'b1;
                                    res_byte     = partial_reg | BYTE_BITS'(sext.value >> 2);
                                    partial_next = {2'(sext.value & LOW2_MASK), 6'b000000};
                                end
                                default:
                                begin
                                    res_valid    = 1'b1;
                                    res_byte     = partial_reg | BYTE_BITS'(sext.value);
                                    partial_next = '0;
                                end
                            endcase
                            phase_next = phase_reg + 2'd1;
                            if (res_valid && count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 2'd0;
            partial_reg   <= '0;
            mode_reg      <= MODE_DATA;
            error_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            partial_reg   <= partial_next;
            mode_reg      <= mode_next;
            error_reg     <= error_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
        if (res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_byte_reg  <= res_byte;
            out_count_reg <= res_count;
        end
    end

    `B64SD_ASSERT_NEXT(a_end_clears_state, advance && in_end_reg,
        phase_reg == 2'd0 && mode_reg == MODE_DATA && !error_reg && count_reg == '0,
        "decoder state not cleared after end of text")

    `B64SD_ASSERT_NOW(a_one_pad_phase, mode_reg == MODE_ONE_PAD, phase_reg == 2'd2,
        "single pad pending outside third quartet position")

    `B64SD_ASSERT_NEXT(a_error_sticky, error_reg && !(advance && in_end_reg), error_reg,
        "error flag dropped before end of text")

    `B64SD_ASSERT_NOW(a_data_count_zero, out_valid_reg && out_kind_reg == KIND_DATA,
        out_count_reg == '0,
        "data result carries a nonzero count")

endmodule

`default_nettype wire

/* dv/tb_base64_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// tb_base64_stream_decoder_unit
// Self-checking bench for the base64 stream decoder. Text characters and
// end-of-text beats go in on the slave stream. A behavioral decoder in the
// bench tracks the quartet, the padding and the error state. It queues the
// byte or verdict that each accepted beat must produce. Every output beat is
// compared against that queue. Directed strings cover the alphabet extremes
// and the padding and error rules. Random strings follow, mostly well formed,
// some broken. Both sides idle at random, and the output side also holds off
// long enough to stall the input.
// ---------------------------------------------------------------------------
module tb_base64_stream_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import b64sd_pkg::*;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        kind_t                     kind;
        logic [BYTE_BITS-1:0]      data;
        logic [OUT_COUNT_BITS-1:0] count;
    } decode_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CHAR_BITS-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    // Decoder state as the bench sees it
    logic [1:0]            dec_phase   = '0;
    logic [BYTE_BITS-1:0]  dec_partial = '0;
    mode_t                 dec_mode    = MODE_DATA;
    logic                  dec_err     = 1'b0;
    logic [COUNT_BITS-1:0] dec_count   = '0;

    decode_result_t       result_q[$];
    logic [CHAR_BITS-1:0] text_q[$];

    int beats_sent        = 0;
    int mismatch_count    = 0;
    int quiet_cycles      = 0;
    int sink_hold_cycles  = 0;
    bit src_idle_on       = 1'b1;
    bit sink_idle_on      = 1'b1;

    base64_stream_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_blank(input logic [CHAR_BITS-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Position of c in the alphabet, -1 when it is not there
    function automatic int sextet_index(input logic [CHAR_BITS-1:0] c);
        for (int k = 0; k < 64; k++)
        begin
            if (c == ALPHABET[k])
                return k;
        end
        return -1;
    endfunction

    function automatic logic [CHAR_BITS-1:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_SPACE : CHAR_TAB + CHAR_BITS'(k);
    endfunction

    // Advance the decoder by one accepted beat and queue what it yields
    task automatic decode_beat(input logic [CHAR_BITS-1:0] c, input logic last);
        decode_result_t       r;
        logic [5:0]           v;
        logic [BYTE_BITS-1:0] data;
        logic                 emit;
        logic                 bad;
        int                   idx;
        emit = 1'b0;
        data = '0;
        if (last)
        begin
            bad = dec_err || (dec_mode == MODE_DATA && dec_phase != 2'd0) ||
                  (dec_mode == MODE_ONE_PAD) ||
                  (dec_mode == MODE_PADDED && dec_partial != '0);
            r.kind  = bad ? KIND_ERR : KIND_OK;
            r.data  = '0;
            r.count = OUT_COUNT_BITS'(dec_count);
            result_q.push_back(r);
            dec_phase   = '0;
            dec_partial = '0;
            dec_mode    = MODE_DATA;
            dec_err     = 1'b0;
            dec_count   = '0;
        end
        else if (dec_err || is_blank(c))
        begin
            // drop: nothing changes
        end
        else if (dec_mode == MODE_PADDED)
        begin
            dec_err = 1'b1;
        end
        else if (dec_mode == MODE_ONE_PAD)
        begin
            if (c == CHAR_PAD)
                dec_mode = MODE_PADDED;
            else
                dec_err = 1'b1;
        end
        else if (c == CHAR_PAD)
        begin
            if (dec_phase == 2'd2)
                dec_mode = MODE_ONE_PAD;
            else if (dec_phase == 2'd3)
                dec_mode = MODE_PADDED;
            else
                dec_err = 1'b1;
        end
        else
        begin
            idx = sextet_index(c);
            if (idx < 0)
            begin
                dec_err = 1'b1;
            end
            else
            begin
                v = 6'(idx);
                case (dec_phase)
                    2'd0:
                    begin
                        dec_partial = {v, 2'b00};
                    end
                    2'd1:
                    begin
                        data        = dec_partial | {4'b0000, v[5:4]};
                        dec_partial = {v[3:0], 4'b0000};
                        emit        = 1'b1;
                    end
                    2'd2:
                    begin
                        data        = dec_partial | {2'b00, v[5:2]};
                        dec_partial = {v[1:0], 6'b000000};
                        emit        = 1'b1;
                    end
                    default:
                    begin
                        data        = dec_partial | {2'b00, v};
                        dec_partial = '0;
                        emit        = 1'b1;
                    end
                endcase
                dec_phase = dec_phase + 2'd1;
            end
        end
        if (emit)
        begin
            if (dec_count != COUNT_MAX)
                dec_count = dec_count + 1'b1;
            r.kind  = KIND_DATA;
            r.data  = data;
            r.count = '0;
            result_q.push_back(r);
        end
    endtask

    task automatic send_beat(input logic [CHAR_BITS-1:0] c, input logic last);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        decode_beat(c, last);
        beats_sent++;
    endtask

    task automatic send_text(input string txt, input logic [CHAR_BITS-1:0] end_char);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], 1'b0);
        send_beat(end_char, 1'b1);
    endtask

    // Hold the input until every queued result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_text(input logic [CHAR_BITS-1:0] c);
        if ($urandom_range(0, 7) == 0)
            text_q.push_back(blank_char());
        text_q.push_back(c);
    endtask

    // One string: whole quartets, an optional padded tail, then end of text.
    // A broken string gets one random mutation before it is sent.
    task automatic send_random_string(input bit broken);
        int nq;
        int tail;
        int sz;
        text_q.delete();
        nq = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        repeat (nq)
        begin
            repeat (4) push_text(ALPHABET[$urandom_range(0, 63)]);
        end
        tail = $urandom_range(0, 3);
        if (tail == 1)
        begin
            push_text(ALPHABET[$urandom_range(0, 63)]);
            // leftover bits are mostly zero, sometimes not
            if ($urandom_range(0, 7) == 0)
                push_text(ALPHABET[$urandom_range(0, 63)]);
            else
                push_text(ALPHABET[$urandom_range(0, 63) & 'h30]);
            push_text(CHAR_PAD);
            push_text(CHAR_PAD);
        end
        else if (tail == 2)
        begin
            push_text(ALPHABET[$urandom_range(0, 63)]);
            push_text(ALPHABET[$urandom_range(0, 63)]);
            if ($urandom_range(0, 7) == 0)
                push_text(ALPHABET[$urandom_range(0, 63)]);
            else
                push_text(ALPHABET[$urandom_range(0, 63) & 'h3C]);
            push_text(CHAR_PAD);
        end
        if ($urandom_range(0, 3) == 0)
            text_q.push_back(blank_char());
        if (broken)
        begin
            sz = text_q.size();
            case ($urandom_range(0, 4))
                0:
                begin
                    if (sz > 0)
                        text_q[$urandom_range(0, sz - 1)] = CHAR_BITS'($urandom_range(0, 255));
                    else
                        text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
                end
                1: text_q.insert($urandom_range(0, sz), CHAR_PAD);
                2: text_q.push_back(ALPHABET[$urandom_range(0, 63)]);
                3:
                begin
                    if (sz > 0)
                        void'(text_q.pop_back());
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
                end
            endcase
        end
        foreach (text_q[i])
            send_beat(text_q[i], 1'b0);
        send_beat(CHAR_BITS'($urandom_range(0, 255)), 1'b1);
    endtask

    // Alphabet extremes, padding split by white space, empty string
    task automatic test_directed_decode();
        send_text("//+/AA=\t=", 8'h00);
        send_beat(8'hFF, 1'b1);
        send_text("AZaz09\n+/", 8'h41);
    endtask

    task automatic test_directed_errors();
        send_text("AB==", 8'h00);   // leftover bits not zero
        send_text("A=", 8'h00);     // pad too early
        send_text("AA=", 8'h00);    // second pad missing at the end
        send_beat(8'h00, 1'b0);     // NUL is foreign, then ignored input
        send_beat(8'h80, 1'b1);
        send_text("Ab9", 8'hFF);    // quartet not finished
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = beats_sent + 1000;
        while (beats_sent < stop_at)
            send_random_string($urandom_range(0, 3) == 0);
    endtask

    // Output holds off while input streams back to back, then the input pauses
    task automatic test_input_backpressure();
        int stop_at;
        src_idle_on      = 1'b0;
        sink_hold_cycles = 300;
        stop_at          = beats_sent + 120;
        while (beats_sent < stop_at)
            send_random_string(1'b0);
        drain_results();
        src_idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        int stop_at;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stop_at      = beats_sent + 100;
        while (beats_sent < stop_at)
            send_random_string($urandom_range(0, 7) == 0);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_decode();
        test_directed_errors();
        test_random_strings();
        test_input_backpressure();
        test_back_to_back();
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Output side: random stalls per beat, plus a long hold when requested
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            stall = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        decode_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected beat, kind %0d data %02h count %0d", $time,
                         m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8]);
                mismatch_count++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (m_axis_tuser !== exp_r.kind)
                begin
                    $display("%0t: result_kind expected %0d, actual %0d", $time,
                             exp_r.kind, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:0] !== exp_r.data)
                begin
                    $display("%0t: data_byte expected %02h, actual %02h", $time,
                             exp_r.data, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[39:8] !== exp_r.count)
                begin
                    $display("%0t: decoded_count expected %0d, actual %0d", $time,
                             exp_r.count, m_axis_tdata[39:8]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

endmodule
